// ===== design/tie_pkg.sv =====
`default_nettype none
package tie_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int GRID_CELLS = 256;
    localparam int NUM_TETRA  = 6;
    // Exact corner positions: origin + 255 * step + step needs 41 bits, kept at 44.
    localparam int POS_W   = 44;
    localparam int MAG_W   = 33;
    localparam int TQ_W    = FRAC_BITS + 1;
    localparam int PROD_W  = MAG_W + TQ_W;
    localparam int OFF_W   = PROD_W - FRAC_BITS;
    localparam int DIV_STAGES = FRAC_BITS;

    typedef logic signed [POS_W-1:0] pos_t;

    typedef enum logic [2:0] {
        REG_ISO_LEVEL = 3'd0,
        REG_X_ORIGIN  = 3'd1,
        REG_Y_ORIGIN  = 3'd2,
        REG_Z_ORIGIN  = 3'd3,
        REG_X_STEP    = 3'd4,
        REG_Y_STEP    = 3'd5,
        REG_Z_STEP    = 3'd6
    } cfg_reg_t;

    // One vertex request handed from the sequencer to the interpolator.
    typedef struct packed {
        logic signed [31:0] v1;
        logic signed [31:0] v2;
        pos_t [2:0]         p1;
        pos_t [2:0]         p2;
        logic [2:0]         tetra;
        logic [1:0]         corner;
        logic               last;
    } tie_job_t;

    localparam logic [2:0] TET_CORNER [NUM_TETRA][4] = '{
        '{3'd0, 3'd7, 3'd3, 3'd2},
        '{3'd0, 3'd7, 3'd2, 3'd6},
        '{3'd0, 3'd4, 3'd7, 3'd6},
        '{3'd0, 3'd1, 3'd6, 3'd2},
        '{3'd0, 3'd4, 3'd6, 3'd1},
        '{3'd5, 3'd1, 3'd6, 3'd4}
    };

    localparam logic [2:0] CASE_COUNT [16] = '{
        3'd0, 3'd3, 3'd3, 3'd6, 3'd3, 3'd6, 3'd6, 3'd3,
        3'd3, 3'd6, 3'd6, 3'd3, 3'd6, 3'd3, 3'd3, 3'd0
    };

    localparam logic [3:0] CASE_EDGE [16][6] = '{
        '{4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0},
        '{4'd1,  4'd3,  4'd2,  4'd0,  4'd0,  4'd0},
        '{4'd4,  4'd6,  4'd7,  4'd0,  4'd0,  4'd0},
        '{4'd12, 4'd8,  4'd7,  4'd8,  4'd9,  4'd7},
        '{4'd8,  4'd11, 4'd9,  4'd0,  4'd0,  4'd0},
        '{4'd12, 4'd6,  4'd4,  4'd6,  4'd12, 4'd11},
        '{4'd1,  4'd2,  4'd7,  4'd7,  4'd2,  4'd14},
        '{4'd12, 4'd14, 4'd13, 4'd0,  4'd0,  4'd0},
        '{4'd13, 4'd14, 4'd12, 4'd0,  4'd0,  4'd0},
        '{4'd1,  4'd7,  4'd2,  4'd7,  4'd14, 4'd2},
        '{4'd12, 4'd4,  4'd6,  4'd6,  4'd11, 4'd12},
        '{4'd9,  4'd11, 4'd8,  4'd0,  4'd0,  4'd0},
        '{4'd7,  4'd8,  4'd12, 4'd8,  4'd7,  4'd9},
        '{4'd4,  4'd7,  4'd6,  4'd0,  4'd0,  4'd0},
        '{4'd1,  4'd2,  4'd3,  4'd0,  4'd0,  4'd0},
        '{4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0}
    };

endpackage
`default_nettype wire

// ===== design/tie_interp.sv =====
`default_nettype none
module tie_interp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                job_valid,
    input  wire tie_pkg::tie_job_t   job,
    input  wire logic signed [31:0]  iso_level,
    output logic                     vertex_valid,
    output logic signed [31:0]       vertex_x,
    output logic signed [31:0]       vertex_y,
    output logic signed [31:0]       vertex_z,
    output logic [2:0]               tetra_number,
    output logic [1:0]               corner_in_triangle,
    output logic                     last_vertex
);
    import tie_pkg::*;

    typedef struct packed {
        logic [MAG_W:0]          rem;
        logic [MAG_W-1:0]        ad;
        logic [FRAC_BITS-1:0]    q;
        logic                    clamp;
        logic                    eq;
        logic                    sneg;
        pos_t [2:0]              p1;
        pos_t [2:0]              mid;
        logic [2:0][MAG_W-1:0]   dmag;
        logic [2:0]              dneg;
        logic [2:0]              tetra;
        logic [1:0]              corner;
        logic                    last;
    } div_st_t;

    typedef struct packed {
        logic [2:0][PROD_W-1:0]  prod;
        logic [2:0]              neg;
        logic                    eq;
        pos_t [2:0]              p1;
        pos_t [2:0]              mid;
        logic [2:0]              tetra;
        logic [1:0]              corner;
        logic                    last;
    } mul_st_t;

    typedef struct packed {
        logic [2:0][OFF_W-1:0]   off;
        logic [2:0]              neg;
        logic                    eq;
        pos_t [2:0]              p1;
        pos_t [2:0]              mid;
        logic [2:0]              tetra;
        logic [1:0]              corner;
        logic                    last;
    } rnd_st_t;

    div_st_t                div_reg [DIV_STAGES+1];
    logic [DIV_STAGES:0]    div_valid_reg;
    div_st_t                div_next [DIV_STAGES+1];
    mul_st_t                mul_reg, mul_next;
    logic                   mul_valid_reg;
    rnd_st_t                rnd_reg, rnd_next;
    logic                   rnd_valid_reg;
    logic signed [31:0]     out_next [3];

    function automatic logic signed [31:0] sat32(input logic signed [POS_W:0] v);
        logic fits;
        fits = (&v[POS_W:31]) | ~(|v[POS_W:31]);
        if (fits)
            sat32 = v[31:0];
        else
            sat32 = v[POS_W] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    endfunction

    // Edge setup: weight numerator and denominator, axis deltas and midpoints.
    always_comb
    begin
        logic signed [MAG_W-1:0] num;
        logic signed [MAG_W-1:0] den;
        logic [MAG_W-1:0]        an;
        pos_t                    d;
        logic signed [POS_W:0]   sum;
        logic [MAG_W:0]          r2;
        num = {iso_level[31], iso_level} - {job.v1[31], job.v1};
        den = {job.v2[31], job.v2} - {job.v1[31], job.v1};
        an  = num[MAG_W-1] ? MAG_W'(-num) : MAG_W'(num);
        div_next[0].ad    = den[MAG_W-1] ? MAG_W'(-den) : MAG_W'(den);
        div_next[0].rem   = {1'b0, an};
        div_next[0].clamp = an >= div_next[0].ad;
        div_next[0].q     = '0;
        div_next[0].eq    = job.v1 == job.v2;
        div_next[0].sneg  = num[MAG_W-1] ^ den[MAG_W-1];
        for (int ax = 0; ax < 3; ax++)
        begin
            d   = job.p2[ax] - job.p1[ax];
            sum = {job.p1[ax][POS_W-1], job.p1[ax]} + {job.p2[ax][POS_W-1], job.p2[ax]};
            div_next[0].p1[ax]   = job.p1[ax];
            div_next[0].mid[ax]  = sum[POS_W:1];
            div_next[0].dneg[ax] = d[POS_W-1];
            div_next[0].dmag[ax] = d[POS_W-1] ? MAG_W'(-d) : MAG_W'(d);
        end
        div_next[0].tetra  = job.tetra;
        div_next[0].corner = job.corner;
        div_next[0].last   = job.last;

        // Restoring division, one quotient bit per stage.
        for (int s = 1; s <= DIV_STAGES; s++)
        begin
            div_next[s] = div_reg[s-1];
            r2 = {div_reg[s-1].rem[MAG_W-1:0], 1'b0};
            if (r2 >= {1'b0, div_reg[s-1].ad})
            begin
                div_next[s].rem = r2 - {1'b0, div_reg[s-1].ad};
                div_next[s].q   = {div_reg[s-1].q[FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                div_next[s].rem = r2;
                div_next[s].q   = {div_reg[s-1].q[FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        logic [TQ_W-1:0] tq;
        div_st_t         dv;
        dv = div_reg[DIV_STAGES];
        tq = dv.clamp ? (TQ_W'(1) << FRAC_BITS) : {1'b0, dv.q};
        for (int ax = 0; ax < 3; ax++)
        begin
            mul_next.prod[ax] = PROD_W'(dv.dmag[ax]) * PROD_W'(tq);
            mul_next.neg[ax]  = dv.dneg[ax] ^ dv.sneg;
        end
        mul_next.eq     = dv.eq;
        mul_next.p1     = dv.p1;
        mul_next.mid    = dv.mid;
        mul_next.tetra  = dv.tetra;
        mul_next.corner = dv.corner;
        mul_next.last   = dv.last;
    end

    always_comb
    begin
        logic [PROD_W-1:0] rsum;
        for (int ax = 0; ax < 3; ax++)
        begin
            rsum = mul_reg.prod[ax] + (PROD_W'(1) << (FRAC_BITS - 1));
            rnd_next.off[ax] = rsum[PROD_W-1:FRAC_BITS];
        end
        rnd_next.neg    = mul_reg.neg;
        rnd_next.eq     = mul_reg.eq;
        rnd_next.p1     = mul_reg.p1;
        rnd_next.mid    = mul_reg.mid;
        rnd_next.tetra  = mul_reg.tetra;
        rnd_next.corner = mul_reg.corner;
        rnd_next.last   = mul_reg.last;
    end

    always_comb
    begin
        logic signed [POS_W:0] offs;
        logic signed [POS_W:0] res;
        for (int ax = 0; ax < 3; ax++)
        begin
            offs = $signed((POS_W + 1)'(rnd_reg.off[ax]));
            if (rnd_reg.eq)
                res = {rnd_reg.mid[ax][POS_W-1], rnd_reg.mid[ax]};
            else if (rnd_reg.neg[ax])
                res = {rnd_reg.p1[ax][POS_W-1], rnd_reg.p1[ax]} - offs;
            else
                res = {rnd_reg.p1[ax][POS_W-1], rnd_reg.p1[ax]} + offs;
            out_next[ax] = sat32(res);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_valid_reg <= '0;
            mul_valid_reg <= 1'b0;
            rnd_valid_reg <= 1'b0;
            vertex_valid  <= 1'b0;
        end
        else
        begin
            div_valid_reg <= {div_valid_reg[DIV_STAGES-1:0], job_valid};
            mul_valid_reg <= div_valid_reg[DIV_STAGES];
            rnd_valid_reg <= mul_valid_reg;
            vertex_valid  <= rnd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s <= DIV_STAGES; s++)
            div_reg[s] <= div_next[s];
        mul_reg            <= mul_next;
        rnd_reg            <= rnd_next;
        vertex_x           <= out_next[0];
        vertex_y           <= out_next[1];
        vertex_z           <= out_next[2];
        tetra_number       <= rnd_reg.tetra;
        corner_in_triangle <= rnd_reg.corner;
        last_vertex        <= rnd_reg.last;
    end

endmodule
`default_nettype wire

// ===== design/tetrahedral_isosurface_extract.sv =====
`default_nettype none
// Channel   Handshake             Payload
// cube      start / busy          cell_x..z, corner_value_0..7
// config    cfg_valid / cfg_ready cfg_index, cfg_data
// vertex    vertex_valid strobe   vertex_x..z, tetra_number, corner_in_triangle, last_vertex
//
// A cube is taken when start is high and busy is low; one cube can wait in the
// product stage while the sequencer walks the previous one. The sequencer takes
// a step per empty tetrahedron and one per vertex. Vertices then pass the job,
// divider, product, rounding and output registers. Reset clears all valid bits
// and loads the register defaults. The vertex side never stalls, so the
// interpolation pipeline runs freely.
module tetrahedral_isosurface_extract (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [7:0]         cell_x,
    input  wire logic [7:0]         cell_y,
    input  wire logic [7:0]         cell_z,
    input  wire logic signed [31:0] corner_value_0,
    input  wire logic signed [31:0] corner_value_1,
    input  wire logic signed [31:0] corner_value_2,
    input  wire logic signed [31:0] corner_value_3,
    input  wire logic signed [31:0] corner_value_4,
    input  wire logic signed [31:0] corner_value_5,
    input  wire logic signed [31:0] corner_value_6,
    input  wire logic signed [31:0] corner_value_7,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    output logic                    vertex_valid,
    output logic signed [31:0]      vertex_x,
    output logic signed [31:0]      vertex_y,
    output logic signed [31:0]      vertex_z,
    output logic [2:0]              tetra_number,
    output logic [1:0]              corner_in_triangle,
    output logic                    last_vertex
);
    import tie_pkg::*;

    logic signed [31:0] iso_reg, x_org_reg, y_org_reg, z_org_reg;
    logic signed [31:0] x_step_reg, y_step_reg, z_step_reg;

    // Product stage.
    logic               p_valid_reg;
    logic signed [40:0] p_mx_reg, p_my_reg, p_mz_reg;
    logic signed [31:0] p_val_reg [8];
    logic [7:0]         p_below_reg;

    // Sequencer.
    logic               seq_active_reg;
    logic [2:0]         seq_t_reg, seq_t_next;
    logic [2:0]         seq_k_reg, seq_k_next;
    logic signed [31:0] seq_val_reg [8];
    pos_t               seq_lo_reg [3];
    pos_t               seq_hi_reg [3];
    logic [3:0]         seq_mask_reg [NUM_TETRA];

    logic               accept, in_grid, seq_take, emit, tetra_done, finishing, rest_nz;
    logic [3:0]         cur_mask;
    logic [2:0]         cur_cnt;
    logic [3:0]         cur_edge;
    logic [2:0]         ca, cb;
    tie_job_t           job_next, job_reg;
    logic               job_valid_reg;
    logic signed [31:0] in_val [8];
    logic [3:0]         load_mask [NUM_TETRA];

    assign in_val[0] = corner_value_0;
    assign in_val[1] = corner_value_1;
    assign in_val[2] = corner_value_2;
    assign in_val[3] = corner_value_3;
    assign in_val[4] = corner_value_4;
    assign in_val[5] = corner_value_5;
    assign in_val[6] = corner_value_6;
    assign in_val[7] = corner_value_7;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iso_reg    <= '0;
            x_org_reg  <= '0;
            y_org_reg  <= '0;
            z_org_reg  <= '0;
            x_step_reg <= 32'sd1 <<< FRAC_BITS;
            y_step_reg <= 32'sd1 <<< FRAC_BITS;
            z_step_reg <= 32'sd1 <<< FRAC_BITS;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ISO_LEVEL: iso_reg    <= cfg_data;
                REG_X_ORIGIN:  x_org_reg  <= cfg_data;
                REG_Y_ORIGIN:  y_org_reg  <= cfg_data;
                REG_Z_ORIGIN:  z_org_reg  <= cfg_data;
                REG_X_STEP:    x_step_reg <= cfg_data;
                REG_Y_STEP:    y_step_reg <= cfg_data;
                REG_Z_STEP:    z_step_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign cur_mask  = seq_mask_reg[seq_t_reg];
    assign cur_cnt   = CASE_COUNT[cur_mask];
    assign cur_edge  = CASE_EDGE[cur_mask][seq_k_reg];
    assign ca        = TET_CORNER[seq_t_reg][cur_edge[3:2]];
    assign cb        = TET_CORNER[seq_t_reg][cur_edge[1:0]];
    assign emit       = seq_active_reg && (cur_cnt != 3'd0);
    assign tetra_done = seq_active_reg && ((cur_cnt == 3'd0) || (seq_k_reg == cur_cnt - 3'd1));
    assign finishing  = tetra_done && (seq_t_reg == 3'(NUM_TETRA - 1));
    assign seq_take   = !seq_active_reg || finishing;
    assign busy       = p_valid_reg && !seq_take;
    assign accept     = start && !busy;
    assign in_grid    = (32'(cell_x) < 32'(GRID_CELLS)) && (32'(cell_y) < 32'(GRID_CELLS))
                        && (32'(cell_z) < 32'(GRID_CELLS));

    // Masks of the six tetrahedra for the cube about to enter the sequencer.
    always_comb
    begin
        for (int t = 0; t < NUM_TETRA; t++)
            for (int k = 0; k < 4; k++)
                load_mask[t][k] = p_below_reg[TET_CORNER[t][k]];
    end

    // The last vertex of a cube is the last one of a tetrahedron with no later output.
    always_comb
    begin
        rest_nz = 1'b0;
        for (int u = 0; u < NUM_TETRA; u++)
            if ((3'(u) > seq_t_reg) && (CASE_COUNT[seq_mask_reg[u]] != 3'd0))
                rest_nz = 1'b1;
    end

    always_comb
    begin
        job_next.v1 = seq_val_reg[ca];
        job_next.v2 = seq_val_reg[cb];
        job_next.p1[0] = (ca[0] ^ ca[1]) ? seq_hi_reg[0] : seq_lo_reg[0];
        job_next.p2[0] = (cb[0] ^ cb[1]) ? seq_hi_reg[0] : seq_lo_reg[0];
        job_next.p1[1] = ca[1] ? seq_hi_reg[1] : seq_lo_reg[1];
        job_next.p2[1] = cb[1] ? seq_hi_reg[1] : seq_lo_reg[1];
        job_next.p1[2] = ca[2] ? seq_hi_reg[2] : seq_lo_reg[2];
        job_next.p2[2] = cb[2] ? seq_hi_reg[2] : seq_lo_reg[2];
        job_next.tetra  = seq_t_reg;
        job_next.corner = (seq_k_reg < 3'd3) ? seq_k_reg[1:0] : 2'(seq_k_reg - 3'd3);
        job_next.last   = tetra_done && !rest_nz;
    end

    always_comb
    begin
        seq_t_next = seq_t_reg;
        seq_k_next = seq_k_reg;
        if (seq_take)
        begin
            seq_t_next = '0;
            seq_k_next = '0;
        end
        else if (tetra_done)
        begin
            seq_t_next = seq_t_reg + 3'd1;
            seq_k_next = '0;
        end
        else
            seq_k_next = seq_k_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg    <= 1'b0;
            seq_active_reg <= 1'b0;
            seq_t_reg      <= '0;
            seq_k_reg      <= '0;
            job_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
                p_valid_reg <= in_grid;
            else if (seq_take)
                p_valid_reg <= 1'b0;
            if (seq_take)
                seq_active_reg <= p_valid_reg;
            seq_t_reg     <= seq_t_next;
            seq_k_reg     <= seq_k_next;
            job_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p_mx_reg <= $signed({1'b0, cell_x}) * x_step_reg;
            p_my_reg <= $signed({1'b0, cell_y}) * y_step_reg;
            p_mz_reg <= $signed({1'b0, cell_z}) * z_step_reg;
            for (int c = 0; c < 8; c++)
            begin
                p_val_reg[c]   <= in_val[c];
                p_below_reg[c] <= in_val[c] < iso_reg;
            end
        end
        if (seq_take)
        begin
            seq_val_reg   <= p_val_reg;
            seq_mask_reg  <= load_mask;
            seq_lo_reg[0] <= POS_W'(x_org_reg) + POS_W'(p_mx_reg);
            seq_lo_reg[1] <= POS_W'(y_org_reg) + POS_W'(p_my_reg);
            seq_lo_reg[2] <= POS_W'(z_org_reg) + POS_W'(p_mz_reg);
            seq_hi_reg[0] <= POS_W'(x_org_reg) + POS_W'(p_mx_reg) + POS_W'(x_step_reg);
            seq_hi_reg[1] <= POS_W'(y_org_reg) + POS_W'(p_my_reg) + POS_W'(y_step_reg);
            seq_hi_reg[2] <= POS_W'(z_org_reg) + POS_W'(p_mz_reg) + POS_W'(z_step_reg);
        end
        job_reg <= job_next;
    end

    tie_interp u_interp (
        .clk                (clk),
        .rst_n              (rst_n),
        .job_valid          (job_valid_reg),
        .job                (job_reg),
        .iso_level          (iso_reg),
        .vertex_valid       (vertex_valid),
        .vertex_x           (vertex_x),
        .vertex_y           (vertex_y),
        .vertex_z           (vertex_z),
        .tetra_number       (tetra_number),
        .corner_in_triangle (corner_in_triangle),
        .last_vertex        (last_vertex)
    );

endmodule
`default_nettype wire
